>>> hdl/quad_batcher_texture_slots_unit_defines.svh
// Assertion macros for the quad batcher.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef QUAD_BATCHER_TEXTURE_SLOTS_UNIT_DEFINES_SVH
`define QUAD_BATCHER_TEXTURE_SLOTS_UNIT_DEFINES_SVH
// implication checked on every clock, reset low disables
`define QBT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define QBT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hdl/qbt_pkg.sv
// Shared types, constants and trig helpers for the quad batcher.
// No dependencies.
package qbt_pkg;
    localparam int IN_W  = 225;
    localparam int OUT_W = 137;

    typedef enum logic [0:0] {
        OP_DRAW  = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    // classified job from front to back
    typedef struct packed {
        logic        flush_only;   // end batch: one flush record
        logic        pre_flush;    // flush before the quad
        logic [16:0] flush_cnt;
        logic [4:0]  slot;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] size_x;
        logic [31:0] size_y;
        logic [15:0] phase;
        logic [31:0] color;
        logic [15:0] tiling;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_TRIG,
        BK_MUL,
        BK_SUM,
        BK_EMIT
    } t_bk_state;

    function automatic logic [14:0] quarter_sine(input logic [4:0] k);
        case (k)
            5'd0:  quarter_sine = 15'd0;
            5'd1:  quarter_sine = 15'd1606;
            5'd2:  quarter_sine = 15'd3196;
            5'd3:  quarter_sine = 15'd4756;
            5'd4:  quarter_sine = 15'd6270;
            5'd5:  quarter_sine = 15'd7723;
            5'd6:  quarter_sine = 15'd9102;
            5'd7:  quarter_sine = 15'd10394;
            5'd8:  quarter_sine = 15'd11585;
            5'd9:  quarter_sine = 15'd12665;
            5'd10: quarter_sine = 15'd13623;
            5'd11: quarter_sine = 15'd14449;
            5'd12: quarter_sine = 15'd15137;
            5'd13: quarter_sine = 15'd15679;
            5'd14: quarter_sine = 15'd16069;
            5'd15: quarter_sine = 15'd16305;
            default: quarter_sine = 15'd16384;
        endcase
    endfunction

    function automatic logic [14:0] sine_quarter(input logic [14:0] u);
        logic [14:0] a;
        logic [14:0] b;
        logic [24:0] prod;
        if (u[14]) begin
            sine_quarter = 15'd16384;
        end else begin
            a    = quarter_sine({1'b0, u[13:10]});
            b    = quarter_sine({1'b0, u[13:10]} + 5'd1);
            prod = 25'(b - a) * 25'(u[9:0]) + 25'd512;
            sine_quarter = a + 15'(prod[24:10]);
        end
    endfunction

    function automatic logic signed [15:0] sine_phase(input logic [15:0] p);
        logic [14:0] v;
        if (p[14]) begin
            v = sine_quarter(15'h4000 - {1'b0, p[13:0]});
        end else begin
            v = sine_quarter({1'b0, p[13:0]});
        end
        sine_phase = p[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction
endpackage

>>> hdl/quad_batcher_texture_slots_unit.sv
// Top level of the sprite quad batcher with texture slots.
// Instantiates qbt_front and qbt_back; uses qbt_pkg.
//
// Usage:
//  Slave stream carries draw / end-batch requests; master stream carries
//  flush and vertex words, tlast on the final word of each request.
//  A draw yields four vertex words, preceded by a flush word when the batch
//  is full in quads or texture slots; an end-batch yields one flush word.
//  Front registers a request, then looks up its slot and classifies it, and
//  queues one job; the back end takes the job and computes sin/cos, then
//  passes a state for the optional flush word and a multiply and a sum
//  state per vertex. It takes no new job until it is back in idle, so draw
//  throughput is set by the back end's sequence of states; an end batch
//  skips the multiply and sum states.
//  Reset (synchronous, active low) empties the batch: slot count 1, quads 0.
//  The slot table has no reset; only entries written this batch are read.
//  A stall on m_axis_tready holds the output register; the front keeps one
//  job queued and then deasserts s_axis_tready.
module quad_batcher_texture_slots_unit #(
    parameter int MAX_QUADS_PER_BATCH = 16384,
    parameter int TEXTURE_SLOT_COUNT  = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, size_x, size_y, rotation, color_rgba, texture_id,
    // tiling_factor
    input  logic [223:0] s_axis_tdata,
    // operation
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // flush_index_count, vert_x, vert_y, tex_u, tex_v, vert_color,
    // tex_slot, vert_tiling
    output logic [135:0] m_axis_tdata,
    // is_flush
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);
    import qbt_pkg::*;

    logic          w_jv, w_jr;
    t_job          w_job;
    logic [OUT_W-1:0] w_od;

    qbt_front #(.QUAD_LIMIT(MAX_QUADS_PER_BATCH), .SLOTS(TEXTURE_SLOT_COUNT)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data({s_axis_tdata, s_axis_tuser}),
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job(w_job)
    );

    qbt_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_jv), .o_job_ready(w_jr), .i_job(w_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(w_od), .o_last(m_axis_tlast)
    );

    assign m_axis_tuser = w_od[0];
    assign m_axis_tdata = w_od[136:1];
endmodule

>>> hdl/qbt_front.sv
// Front end: accepts requests, keeps batch counters and the slot table.
// Uses qbt_pkg. Looks up and classifies a request before the next.
module qbt_front #(
    parameter int QUAD_LIMIT = 16384,
    parameter int SLOTS      = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [qbt_pkg::IN_W-1:0] i_data,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output qbt_pkg::t_job         o_job
);
    import qbt_pkg::*;
    `include "quad_batcher_texture_slots_unit_defines.svh"

    localparam int QW = $clog2(QUAD_LIMIT + 1);

    logic [31:0]   r_table [32];
    logic [5:0]    r_used;
    logic [QW-1:0] r_quads;
    logic          r_busy;
    logic [IN_W-1:0] r_req;
    logic          r_out_v;
    t_job          r_job;

    logic [31:0] w_tex;
    logic        w_full;
    logic [5:0]  w_base;
    logic [4:0]  w_hit_slot;
    logic        w_hit;
    logic [47:0] w_ang;
    logic [15:0] w_phase;

    assign o_ready     = !r_busy && (!r_out_v || i_job_ready);
    assign o_job_valid = r_out_v;
    assign o_job       = r_job;
    assign w_tex       = r_req[208:177];
    assign w_full      = (r_quads >= QW'(QUAD_LIMIT)) || (r_used >= 6'(SLOTS));
    assign w_base      = w_full ? 6'd1 : r_used;

    always_comb begin
        w_hit      = 1'b0;
        w_hit_slot = '0;
        for (int i = 31; i >= 1; i--) begin
            if (6'(i) < w_base && r_table[i] == w_tex) begin
                w_hit      = 1'b1;
                w_hit_slot = 5'(i);
            end
        end
    end

    // phase = floor(rot * 166886 / 2^16) mod 2^16
    assign w_ang   = 48'($signed(r_req[144:129])) * 48'sd166886;
    assign w_phase = w_ang[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_out_v <= 1'b0;
            r_used  <= 6'd1;
            r_quads <= '0;
        end else begin
            if (r_out_v && i_job_ready) r_out_v <= 1'b0;
            if (i_valid && o_ready) begin
                r_req  <= i_data;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy  <= 1'b0;
                r_out_v <= 1'b1;
                r_job.flush_cnt <= 17'(r_quads) * 17'd6;
                r_job.pos_x   <= r_req[32:1];
                r_job.pos_y   <= r_req[64:33];
                r_job.size_x  <= r_req[96:65];
                r_job.size_y  <= r_req[128:97];
                r_job.phase   <= w_phase;
                r_job.color   <= r_req[176:145];
                r_job.tiling  <= r_req[224:209];
                if (t_op'(r_req[0]) == OP_FLUSH) begin
                    r_job.flush_only <= 1'b1;
                    r_job.pre_flush  <= 1'b0;
                    r_used  <= 6'd1;
                    r_quads <= '0;
                end else begin
                    r_job.flush_only <= 1'b0;
                    r_job.pre_flush  <= w_full;
                    r_quads <= (w_full ? QW'(0) : r_quads) + QW'(1);
                    if (w_hit) begin
                        r_job.slot <= w_hit_slot;
                        r_used     <= w_base;
                    end else begin
                        r_job.slot <= w_base[4:0];
                        r_table[w_base[4:0]] <= w_tex;
                        r_used <= w_base + 6'd1;
                    end
                end
            end
        end
    end

    `QBT_ASSERT_NXT(a_busy_one, i_clk, i_rst_n, r_busy, !r_busy, "front busy stuck")
    `QBT_ASSERT_IMP(a_used_rng, i_clk, i_rst_n, 1'b1, r_used >= 6'd1 && r_used <= 6'd32,
        "slot count out of range")
    `QBT_ASSERT_IMP(a_no_take, i_clk, i_rst_n, r_busy, !o_ready, "accept while busy")
endmodule

>>> hdl/qbt_back.sv
// Back end: computes trig, rotates corners, emits flush and vertex words.
// Uses qbt_pkg; consumes jobs from the front queue.
module qbt_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    output logic                   o_job_ready,
    input  qbt_pkg::t_job          i_job,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [qbt_pkg::OUT_W-1:0] o_data,
    output logic                   o_last
);
    import qbt_pkg::*;
    `include "quad_batcher_texture_slots_unit_defines.svh"

    t_bk_state r_state, n_state;
    t_job      r_job;
    logic signed [15:0] r_sin, r_cos;
    logic signed [47:0] r_cx, r_cy, r_sx, r_sy;
    logic [1:0]  r_k;
    logic        r_pre;
    logic        r_ov;
    logic [OUT_W-1:0] r_od;
    logic        r_ol;

    logic signed [32:0] w_x, w_y;
    logic signed [49:0] w_rx, w_ry;
    logic [31:0] w_vx, w_vy;
    logic        w_can;
    logic        w_take;
    logic        w_emit;

    assign o_valid = r_ov;
    assign o_data  = r_od;
    assign o_last  = r_ol;
    assign w_can   = !r_ov || i_ready;
    assign o_job_ready = (r_state == BK_IDLE);
    assign w_take  = i_job_valid && o_job_ready;
    assign w_emit  = w_can && ((r_state == BK_TRIG && (r_job.flush_only || r_pre))
                               || r_state == BK_SUM);

    // corner k: x sign -,+,+,- ; y sign -,-,+,+
    assign w_x = (r_k == 2'd1 || r_k == 2'd2) ? $signed({r_job.size_x[31], r_job.size_x})
               : -$signed({r_job.size_x[31], r_job.size_x});
    assign w_y = r_k[1] ? $signed({r_job.size_y[31], r_job.size_y})
               : -$signed({r_job.size_y[31], r_job.size_y});
    assign w_rx = 50'(r_cx) - 50'(r_sy) + 50'sd16384;
    assign w_ry = 50'(r_sx) + 50'(r_cy) + 50'sd16384;
    assign w_vx = r_job.pos_x + w_rx[46:15];
    assign w_vy = r_job.pos_y + w_ry[46:15];

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (w_take) n_state = BK_TRIG;
            BK_TRIG: begin
                if (r_job.flush_only || r_pre) begin
                    if (w_can) n_state = r_job.flush_only ? BK_IDLE : BK_MUL;
                end else begin
                    n_state = BK_MUL;
                end
            end
            BK_MUL:  n_state = BK_SUM;
            BK_SUM:  if (w_can) n_state = (r_k == 2'd3) ? BK_IDLE : BK_MUL;
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            case (r_state)
                BK_IDLE: begin
                    if (w_take) begin
                        r_job <= i_job;
                        r_pre <= i_job.pre_flush;
                        r_k   <= 2'd0;
                        r_sin <= sine_phase(i_job.phase);
                        r_cos <= sine_phase(i_job.phase + 16'h4000);
                    end
                end
                BK_TRIG: begin
                    if ((r_job.flush_only || r_pre) && w_can) begin
                        r_od <= {119'd0, r_job.flush_cnt, 1'b1};
                        r_ol <= r_job.flush_only;
                        r_pre <= 1'b0;
                    end
                end
                BK_MUL: begin
                    r_cx <= 48'(r_cos) * 48'(w_x);
                    r_sy <= 48'(r_sin) * 48'(w_y);
                    r_sx <= 48'(r_sin) * 48'(w_x);
                    r_cy <= 48'(r_cos) * 48'(w_y);
                end
                BK_SUM: begin
                    if (w_can) begin
                        r_od <= {r_job.tiling, r_job.slot, r_job.color,
                                 r_k[1], (r_k == 2'd1 || r_k == 2'd2),
                                 w_vy, w_vx, 17'd0, 1'b0};
                        r_ol <= (r_k == 2'd3);
                        r_k  <= r_k + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    `QBT_ASSERT_NXT(a_mul_sum, i_clk, i_rst_n, r_state == BK_MUL, r_state == BK_SUM,
        "multiply stage not followed by sum")
    `QBT_ASSERT_IMP(a_idle_ready, i_clk, i_rst_n, r_state != BK_IDLE, !o_job_ready,
        "job taken while busy")
    `QBT_ASSERT_IMP(a_emit_hold, i_clk, i_rst_n, r_state == BK_SUM && !w_can,
        r_ov && !i_ready, "sum stage stalled without output stall")
endmodule
